// ===== src/dptb_pkg.sv =====
package dptb_pkg;

    localparam int ADDR_W = 64;
    localparam int PAGE_W = 52;
    localparam int CNT_W  = 3;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NULL   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX      = 3'd7;
    localparam logic [CNT_W-1:0] THRESH_RESET = 3'd6;

endpackage

// ===== src/dptb_if.sv =====
interface dptb_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [1:0]                  thread;
    logic [dptb_pkg::ADDR_W-1:0] instr_addr;
    logic [dptb_pkg::PAGE_W-1:0] page_number;
    logic [dptb_pkg::PAGE_W-1:0] fill_ppn;
    logic                        was_used;

    modport source (output valid, operation, thread, instr_addr, page_number, fill_ppn,
                    was_used, input ready);
    modport sink (input valid, operation, thread, instr_addr, page_number, fill_ppn,
                  was_used, output ready);
endinterface

interface dptb_out_if;
    logic                        valid;
    logic                        ready;
    logic                        shadow_hit;
    logic [dptb_pkg::PAGE_W-1:0] hit_ppn;
    logic                        bypass;
    logic                        evict_valid;
    logic [dptb_pkg::PAGE_W-1:0] evict_vpn;
    logic [dptb_pkg::PAGE_W-1:0] evict_ppn;

    modport source (output valid, shadow_hit, hit_ppn, bypass, evict_valid, evict_vpn,
                    evict_ppn, input ready);
    modport sink (input valid, shadow_hit, hit_ppn, bypass, evict_valid, evict_vpn,
                  evict_ppn, output ready);
endinterface

// ===== src/dptb_front.sv =====
module dptb_front #(
    parameter int THREADS        = 4,
    parameter int IP_HASH_BITS   = 6,
    parameter int PAGE_HASH_BITS = 4
) (
    dptb_in_if.sink i_req,
    input  logic    i_busy,
    output logic    o_push_valid,
    input  logic    i_push_ready,
    output logic [dptb_pkg::OP_W + ((THREADS > 1) ? $clog2(THREADS) : 1) + IP_HASH_BITS
                  + PAGE_HASH_BITS + 2*dptb_pkg::PAGE_W : 0] o_push_cmd
);
    import dptb_pkg::*;

    localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int IP_CH  = (ADDR_W + IP_HASH_BITS - 1) / IP_HASH_BITS;
    localparam int IP_PAD = IP_CH * IP_HASH_BITS;
    localparam int PG_CH  = (PAGE_W + PAGE_HASH_BITS - 1) / PAGE_HASH_BITS;
    localparam int PG_PAD = PG_CH * PAGE_HASH_BITS;

    logic [IP_PAD-1:0]         ipx;
    logic [PG_PAD-1:0]         pgx;
    logic [IP_HASH_BITS-1:0]   hi;
    logic [PAGE_HASH_BITS-1:0] hp;
    logic [OP_W-1:0]           op;

    // xor fold of the zero-padded words
    always_comb begin
        ipx = IP_PAD'(i_req.instr_addr);
        pgx = PG_PAD'(i_req.page_number);
        hi  = '0;
        hp  = '0;
        for (int k = 0; k < IP_CH; k++) begin
            hi = hi ^ ipx[k*IP_HASH_BITS +: IP_HASH_BITS];
        end
        for (int k = 0; k < PG_CH; k++) begin
            hp = hp ^ pgx[k*PAGE_HASH_BITS +: PAGE_HASH_BITS];
        end
        if (32'(i_req.thread) >= THREADS) begin
            op = OP_NULL;
        end else begin
            op = i_req.operation;
        end
    end

    assign o_push_cmd   = {op, TW'(i_req.thread), hi, hp, i_req.page_number, i_req.fill_ppn,
                           i_req.was_used};
    assign o_push_valid = i_req.valid && !i_busy;
    assign i_req.ready  = i_push_ready && !i_busy;

endmodule

// ===== src/dptb_queue.sv =====
module dptb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== src/dptb_back.sv =====
module dptb_back #(
    parameter int THREADS        = 4,
    parameter int IP_HASH_BITS   = 6,
    parameter int PAGE_HASH_BITS = 4,
    parameter int SHADOW_ENTRIES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [dptb_pkg::CNT_W-1:0] i_cfg_data,
    output logic                 o_busy,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  logic [dptb_pkg::OP_W + ((THREADS > 1) ? $clog2(THREADS) : 1) + IP_HASH_BITS
                  + PAGE_HASH_BITS + 2*dptb_pkg::PAGE_W : 0] i_pop_cmd,
    dptb_out_if.source           o_rsp
);
    import dptb_pkg::*;

    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SW    = (SHADOW_ENTRIES > 1) ? $clog2(SHADOW_ENTRIES) : 1;
    localparam int ROWS  = 1 << IP_HASH_BITS;
    localparam int COLS  = 1 << PAGE_HASH_BITS;
    localparam int ROW_W = CNT_W * COLS;
    localparam int DEPTH = THREADS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    // counter rows, one per thread and instruction hash
    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] r_rd;
    logic             we;
    logic [AW-1:0]    wa;
    logic [ROW_W-1:0] wd;
    logic [AW-1:0]    ra;

    logic [1:0]                r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    logic [IP_HASH_BITS:0]     r_row, n_row;
    logic [CNT_W-1:0]          r_threshold;
    logic [SW-1:0]             r_ptr, n_ptr;
    logic [PAGE_W-1:0]         r_svpn [THREADS][SHADOW_ENTRIES];
    logic [PAGE_W-1:0]         r_sppn [THREADS][SHADOW_ENTRIES];
    logic [PAGE_W-1:0]         n_svpn [THREADS][SHADOW_ENTRIES];
    logic [PAGE_W-1:0]         n_sppn [THREADS][SHADOW_ENTRIES];

    logic [OP_W-1:0]           r_op;
    logic [TW-1:0]             r_t;
    logic [IP_HASH_BITS-1:0]   r_hi;
    logic [PAGE_HASH_BITS-1:0] r_hp;
    logic [PAGE_W-1:0]         r_vpn;
    logic [PAGE_W-1:0]         r_ppn;
    logic                      r_used;

    logic                      r_out_valid, n_out_valid;
    logic                      r_hit, n_hit;
    logic [PAGE_W-1:0]         r_hit_ppn, n_hit_ppn;
    logic                      r_bypass, n_bypass;
    logic                      r_ev_valid, n_ev_valid;
    logic [PAGE_W-1:0]         r_ev_vpn, n_ev_vpn;
    logic [PAGE_W-1:0]         r_ev_ppn, n_ev_ppn;

    logic                      take;
    logic [CNT_W-1:0]          cnt;
    logic [CNT_W-1:0]          cnt_new;
    logic                      match_any;
    logic [SW-1:0]             match_idx;
    logic                      empty_any;
    logic [SW-1:0]             empty_idx;
    logic [SW-1:0]             slot;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    assign o_busy      = (r_state == S_CLEAR);
    assign o_pop_ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign take        = i_pop_valid && o_pop_ready;
    assign cnt         = r_rd[r_hp*CNT_W +: CNT_W];
    assign cnt_new     = r_used ? '0 : ((cnt == CNT_MAX) ? cnt : cnt + 1'b1);

    // first matching and first empty slot of the thread
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        empty_any = 1'b0;
        empty_idx = '0;
        for (int s = SHADOW_ENTRIES - 1; s >= 0; s--) begin
            if (r_svpn[r_t][s] == r_vpn) begin
                match_any = 1'b1;
                match_idx = SW'(s);
            end
            if (r_svpn[r_t][s] == '0) begin
                empty_any = 1'b1;
                empty_idx = SW'(s);
            end
        end
        slot = empty_any ? empty_idx : r_ptr;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_ptr       = r_ptr;
        n_svpn      = r_svpn;
        n_sppn      = r_sppn;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_hit_ppn   = r_hit_ppn;
        n_bypass    = r_bypass;
        n_ev_valid  = r_ev_valid;
        n_ev_vpn    = r_ev_vpn;
        n_ev_ppn    = r_ev_ppn;
        we          = 1'b0;
        wa          = AW'({r_t, r_hi});
        wd          = r_rd;
        ra          = AW'({r_t, r_hi});

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                wd    = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ra = AW'(i_pop_cmd[2*PAGE_W + 1 + PAGE_HASH_BITS +: TW + IP_HASH_BITS]);
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_hit       = 1'b0;
                n_hit_ppn   = '0;
                n_bypass    = 1'b0;
                n_ev_valid  = 1'b0;
                n_ev_vpn    = '0;
                n_ev_ppn    = '0;
                case (r_op)
                    OP_LOOKUP: begin
                        if (r_vpn != '0 && match_any) begin
                            n_hit                  = 1'b1;
                            n_hit_ppn              = r_sppn[r_t][match_idx];
                            n_svpn[r_t][match_idx] = '0;
                            n_sppn[r_t][match_idx] = '0;
                            n_row                  = '0;
                            n_state                = S_SWEEP;
                        end
                    end
                    OP_FILL: begin
                        if (cnt > r_threshold) begin
                            n_bypass = 1'b1;
                            if (r_vpn != '0 && !match_any) begin
                                if (!empty_any) begin
                                    n_ev_valid = 1'b1;
                                    n_ev_vpn   = r_svpn[r_t][r_ptr];
                                    n_ev_ppn   = r_sppn[r_t][r_ptr];
                                    n_ptr      = (r_ptr == SW'(SHADOW_ENTRIES - 1)) ?
                                                 '0 : r_ptr + 1'b1;
                                end
                                n_svpn[r_t][slot] = r_vpn;
                                n_sppn[r_t][slot] = r_ppn;
                            end
                        end
                    end
                    OP_EVICT: begin
                        we = 1'b1;
                        for (int c = 0; c < COLS; c++) begin
                            if (PAGE_HASH_BITS'(c) == r_hp) begin
                                wd[c*CNT_W +: CNT_W] = cnt_new;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_SWEEP: begin
                // read row n while writing back row n-1 with the column cleared
                ra    = AW'({r_t, r_row[IP_HASH_BITS-1:0]});
                wa    = AW'({r_t, IP_HASH_BITS'(r_row - 1'b1)});
                we    = (r_row != '0);
                n_row = r_row + 1'b1;
                for (int c = 0; c < COLS; c++) begin
                    if (PAGE_HASH_BITS'(c) == r_hp) begin
                        wd[c*CNT_W +: CNT_W] = '0;
                    end
                end
                if (r_row == (IP_HASH_BITS+1)'(ROWS)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            {r_op, r_t, r_hi, r_hp, r_vpn, r_ppn, r_used} <= i_pop_cmd;
        end
        r_hit     <= n_hit;
        r_hit_ppn <= n_hit_ppn;
        r_bypass  <= n_bypass;
        r_ev_valid <= n_ev_valid;
        r_ev_vpn  <= n_ev_vpn;
        r_ev_ppn  <= n_ev_ppn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_threshold <= THRESH_RESET;
            r_out_valid <= 1'b0;
            for (int t = 0; t < THREADS; t++) begin
                for (int s = 0; s < SHADOW_ENTRIES; s++) begin
                    r_svpn[t][s] <= '0;
                    r_sppn[t][s] <= '0;
                end
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_row       <= n_row;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            r_svpn      <= n_svpn;
            r_sppn      <= n_sppn;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.shadow_hit  = r_hit;
    assign o_rsp.hit_ppn     = r_hit_ppn;
    assign o_rsp.bypass      = r_bypass;
    assign o_rsp.evict_valid = r_ev_valid;
    assign o_rsp.evict_vpn   = r_ev_vpn;
    assign o_rsp.evict_ppn   = r_ev_ppn;

endmodule

// ===== src/dead_page_tlb_bypass_predictor.sv =====
// Dead-page TLB bypass predictor. Requests enter on i_req, are hashed and queued (two
// entries), and the back end answers each with exactly one result on o_rsp. In the back
// end a request first reads the counter row of its thread and instruction hash from the
// counter memory (one read and one write port), then decides and writes back.
// A lookup that hits in the shadow table then walks all 2**IP_HASH_BITS rows of its
// thread to clear the page-hash column, one row a cycle, and no new request is taken
// until the walk is done. After reset the counter memory is cleared row by row, during
// which i_req.ready stays low; the threshold write port works throughout.
module dead_page_tlb_bypass_predictor #(
    parameter int THREADS        = 4,
    parameter int IP_HASH_BITS   = 6,
    parameter int PAGE_HASH_BITS = 4,
    parameter int SHADOW_ENTRIES = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dptb_pkg::CNT_W-1:0] i_cfg_data,
    dptb_in_if.sink                    i_req,
    dptb_out_if.source                 o_rsp
);
    import dptb_pkg::*;

    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CMD_W = OP_W + TW + IP_HASH_BITS + PAGE_HASH_BITS + 2*PAGE_W + 1;

    logic             busy;
    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_cmd;
    logic             pop_valid;
    logic             pop_ready;
    logic [CMD_W-1:0] pop_cmd;

    dptb_front #(
        .THREADS(THREADS), .IP_HASH_BITS(IP_HASH_BITS), .PAGE_HASH_BITS(PAGE_HASH_BITS)
    ) u_front (
        .i_req(i_req), .i_busy(busy), .o_push_valid(push_valid),
        .i_push_ready(push_ready), .o_push_cmd(push_cmd)
    );

    dptb_queue #(.WIDTH(CMD_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(push_valid), .o_push_ready(push_ready), .i_push_data(push_cmd),
        .o_pop_valid(pop_valid), .i_pop_ready(pop_ready), .o_pop_data(pop_cmd)
    );

    dptb_back #(
        .THREADS(THREADS), .IP_HASH_BITS(IP_HASH_BITS), .PAGE_HASH_BITS(PAGE_HASH_BITS),
        .SHADOW_ENTRIES(SHADOW_ENTRIES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_busy(busy), .i_pop_valid(pop_valid), .o_pop_ready(pop_ready),
        .i_pop_cmd(pop_cmd), .o_rsp(o_rsp)
    );

endmodule
